// File: rtl/lrc_pkg.sv
// Shared types and constants for the line rasterizer with clipping.
// Used by the interfaces, the front, the queue, the back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lrc_pkg;

  localparam int COORD_W     = 12;   // signed endpoint width
  localparam int DELTA_W     = 13;   // magnitude of an endpoint difference
  localparam int ERR_W       = 14;   // Bresenham error term, signed
  localparam int PIX_W       = 6;    // screen coordinate width
  localparam int DATA_W      = 8;    // pixel value width
  localparam int SCREEN_W_DEF = 64;
  localparam int SCREEN_H_DEF = 64;
  localparam int QUEUE_DEPTH = 2;    // setup records between front and back

  // One classified line, ready for stepping.
  typedef struct packed {
    logic signed [COORD_W-1:0] major_pos;
    logic signed [COORD_W-1:0] major_end;
    logic signed [COORD_W-1:0] minor_pos;
    logic [DELTA_W-1:0]        delta_major;
    logic [DELTA_W-1:0]        delta_minor;
    logic                      steep_flag;
    logic                      minor_down;
    logic [DATA_W-1:0]         pixel_value;
  } setup_t;

  // One result item.
  typedef struct packed {
    logic              write_valid;
    logic [PIX_W-1:0]  pixel_x;
    logic [PIX_W-1:0]  pixel_y;
    logic [DATA_W-1:0] pixel_data;
    logic              last_of_line;
  } pix_t;

endpackage

`default_nettype wire

// File: rtl/lrc_if.sv
// Valid/ready channel interfaces: line requests in, pixel results out.
// Depends on lrc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lrc_req_if;
  logic                              valid;
  logic                              ready;
  logic signed [lrc_pkg::COORD_W-1:0] start_x;
  logic signed [lrc_pkg::COORD_W-1:0] start_y;
  logic signed [lrc_pkg::COORD_W-1:0] end_x;
  logic signed [lrc_pkg::COORD_W-1:0] end_y;
  logic [lrc_pkg::DATA_W-1:0]         pixel_value;

  modport source (output valid, start_x, start_y, end_x, end_y, pixel_value,
                  input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, pixel_value,
                  output ready);
endinterface

interface lrc_pix_if;
  logic                       valid;
  logic                       ready;
  logic                       write_valid;
  logic [lrc_pkg::PIX_W-1:0]  pixel_x;
  logic [lrc_pkg::PIX_W-1:0]  pixel_y;
  logic [lrc_pkg::DATA_W-1:0] pixel_data;
  logic                       last_of_line;

  modport source (output valid, write_valid, pixel_x, pixel_y, pixel_data, last_of_line,
                  input ready);
  modport sink   (input valid, write_valid, pixel_x, pixel_y, pixel_data, last_of_line,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/line_rasterizer_with_clipping_unit.sv
// Top level of the Bresenham line rasterizer with screen clipping.
// Depends on lrc_pkg, lrc_if, lrc_front, lrc_queue and lrc_back.
// Order: a request passes the front register and the queue before the stepper loads
//   it; each write goes out as the next visible point is stepped, the last one after.
// Throughput: one major-axis point per cycle unless output stalls, one line at a time.
// Reset: synchronous, active low; clears all handshake and control state.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer_with_clipping_unit #(
  parameter int SCREEN_WIDTH  = lrc_pkg::SCREEN_W_DEF,   // 1 to 64
  parameter int SCREEN_HEIGHT = lrc_pkg::SCREEN_H_DEF    // 1 to 64
) (
  input  logic      clk,
  input  logic      rst_n,
  lrc_req_if.sink   in_req,    // line request: endpoints and pixel value
  lrc_pix_if.source out_pix    // pixel writes, last one of a line marked
);

  // Front -> queue: one classified line per request (steep flag, ordered
  // endpoints, minor step direction, absolute deltas).
  lrc_pkg::setup_t push_data, pop_data;
  logic            push_valid, push_ready;
  logic            pop_valid, pop_ready;

  // Front: input register plus classification. It keeps taking requests
  // while the back end is still drawing, as long as the queue has room.
  lrc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // Queue decouples classification from stepping.
  lrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // Back: Bresenham stepper. Visible points go through a one-point hold
  // register so the final write of a line can carry the last mark; a line
  // with no visible point ends with a single non-write result. A stalled
  // output holds the stepper.
  lrc_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_pix   (out_pix)
  );

endmodule

`default_nettype wire

// File: rtl/lrc_front.sv
// Front end: registers a line request and classifies it (steep, order, step sign).
// Depends on lrc_pkg and lrc_req_if.
`timescale 1ns / 1ps
`default_nettype none

module lrc_front (
  input  logic            clk,
  input  logic            rst_n,
  lrc_req_if.sink         in_req,
  output lrc_pkg::setup_t push_data,
  output logic            push_valid,
  input  logic            push_ready
);

  localparam int CW = lrc_pkg::COORD_W;
  localparam int DW = lrc_pkg::DELTA_W;

  logic                         req_v_r;
  logic signed [CW-1:0]         ax_r, ay_r, bx_r, by_r;
  logic [lrc_pkg::DATA_W-1:0]   data_r;

  logic signed [DW-1:0] dx, dy, dmin, dmaj;
  logic [DW-1:0]        adx, ady;
  logic                 steep, swap;
  logic signed [CW-1:0] amaj, amin, bmaj, bmin;

  assign in_req.ready = !req_v_r || push_ready;
  assign push_valid   = req_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else if (in_req.ready) begin
      req_v_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      ax_r   <= in_req.start_x;
      ay_r   <= in_req.start_y;
      bx_r   <= in_req.end_x;
      by_r   <= in_req.end_y;
      data_r <= in_req.pixel_value;
    end
  end

  always_comb begin
    dx   = $signed({bx_r[CW-1], bx_r}) - $signed({ax_r[CW-1], ax_r});
    dy   = $signed({by_r[CW-1], by_r}) - $signed({ay_r[CW-1], ay_r});
    adx  = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady  = dy[DW-1] ? DW'(-dy) : DW'(dy);
    steep = ady > adx;
    dmaj = steep ? dy : dx;
    dmin = steep ? dx : dy;
    amaj = steep ? ay_r : ax_r;
    amin = steep ? ax_r : ay_r;
    bmaj = steep ? by_r : bx_r;
    bmin = steep ? bx_r : by_r;
    // endpoints are swapped when the major coordinate would decrease
    swap = dmaj[DW-1];

    push_data.major_pos   = swap ? bmaj : amaj;
    push_data.major_end   = swap ? amaj : bmaj;
    push_data.minor_pos   = swap ? bmin : amin;
    push_data.delta_major = steep ? ady : adx;
    push_data.delta_minor = steep ? adx : ady;
    push_data.steep_flag  = steep;
    push_data.minor_down  = swap ? !dmin[DW-1] : (dmin[DW-1] || (dmin == '0));
    push_data.pixel_value = data_r;
  end

endmodule

`default_nettype wire

// File: rtl/lrc_queue.sv
// Short queue of classified lines between front and back.
// Depends on lrc_pkg (setup_t, QUEUE_DEPTH).
`timescale 1ns / 1ps
`default_nettype none

module lrc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  lrc_pkg::setup_t push_data,
  input  logic            push_valid,
  output logic            push_ready,
  output lrc_pkg::setup_t pop_data,
  output logic            pop_valid,
  input  logic            pop_ready
);

  localparam int DEPTH = lrc_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  lrc_pkg::setup_t  q_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  cnt_r;
  logic             do_push, do_pop;

  assign push_ready = cnt_r != CNTW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= CNTW'(cnt_r + 1'b1);
        2'b01:   cnt_r <= CNTW'(cnt_r - 1'b1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

// File: rtl/lrc_back.sv
// Back end: steps one major-axis point per unstalled cycle, clips to the
// screen, emits pixel writes and marks the last. Uses lrc_pkg, lrc_pix_if.
`timescale 1ns / 1ps
`default_nettype none

module lrc_back #(
  parameter int SCREEN_WIDTH  = lrc_pkg::SCREEN_W_DEF,
  parameter int SCREEN_HEIGHT = lrc_pkg::SCREEN_H_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lrc_pkg::setup_t pop_data,
  input  logic            pop_valid,
  output logic            pop_ready,
  lrc_pix_if.source       out_pix
);

  localparam int CW = lrc_pkg::COORD_W;
  localparam int DW = lrc_pkg::DELTA_W;
  localparam int EW = lrc_pkg::ERR_W;
  localparam int PW = lrc_pkg::PIX_W;
  localparam int SW = EW + 2;   // width of 2*(error + delta_minor)

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_STEP = 3'b010,
    S_LAST = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic signed [CW-1:0]       major_pos_r, major_end_r, minor_pos_r;
  logic signed [EW-1:0]       error_r;
  logic [DW-1:0]              dmaj_r, dmin_r;
  logic                       steep_r, down_r;
  logic [lrc_pkg::DATA_W-1:0] data_r;

  logic                       hold_v_r;
  logic [PW-1:0]              hold_x_r, hold_y_r;
  logic                       out_v_r;
  lrc_pkg::pix_t              out_r;

  logic signed [CW-1:0] px, py;
  logic                 vis, out_free, need_push, stall, minor_step, at_end;
  logic                 out_load;
  logic signed [SW-1:0] err_sum, twice;
  logic signed [EW-1:0] err_nxt;

  assign out_free  = !out_v_r || out_pix.ready;
  assign pop_ready = state_r == S_IDLE;
  // output register takes a new result this cycle
  assign out_load  = ((state_r == S_STEP) && !stall && need_push) ||
                     ((state_r == S_LAST) && out_free);

  always_comb begin
    px  = steep_r ? minor_pos_r : major_pos_r;
    py  = steep_r ? major_pos_r : minor_pos_r;
    vis = !px[CW-1] && (px[CW-2:0] < (CW-1)'(SCREEN_WIDTH)) &&
          !py[CW-1] && (py[CW-2:0] < (CW-1)'(SCREEN_HEIGHT));
    need_push = vis && hold_v_r;
    stall     = need_push && !out_free;
    at_end    = major_pos_r == major_end_r;
    err_sum   = SW'(error_r) + $signed({{(SW-DW){1'b0}}, dmin_r});
    twice     = err_sum <<< 1;
    minor_step = twice >= $signed({{(SW-DW){1'b0}}, dmaj_r});
    err_nxt   = minor_step ? EW'(err_sum - $signed({{(SW-DW){1'b0}}, dmaj_r}))
                           : EW'(err_sum);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (pop_valid) state_nxt = S_STEP;
      S_STEP:  if (!stall && at_end) state_nxt = S_LAST;
      S_LAST:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_pix.ready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_STEP: begin
          if (!stall) begin
            if (vis) hold_v_r <= 1'b1;
          end
        end
        S_LAST: begin
          if (out_free) begin
            hold_v_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          major_pos_r <= pop_data.major_pos;
          major_end_r <= pop_data.major_end;
          minor_pos_r <= pop_data.minor_pos;
          dmaj_r      <= pop_data.delta_major;
          dmin_r      <= pop_data.delta_minor;
          steep_r     <= pop_data.steep_flag;
          down_r      <= pop_data.minor_down;
          data_r      <= pop_data.pixel_value;
          error_r     <= '0;
        end
      end
      S_STEP: begin
        if (!stall) begin
          if (need_push) begin
            out_r.write_valid  <= 1'b1;
            out_r.pixel_x      <= hold_x_r;
            out_r.pixel_y      <= hold_y_r;
            out_r.pixel_data   <= data_r;
            out_r.last_of_line <= 1'b0;
          end
          if (vis) begin
            hold_x_r <= px[PW-1:0];
            hold_y_r <= py[PW-1:0];
          end
          if (minor_step) begin
            minor_pos_r <= down_r ? CW'(minor_pos_r - 1'b1) : CW'(minor_pos_r + 1'b1);
          end
          error_r     <= err_nxt;
          major_pos_r <= CW'(major_pos_r + 1'b1);
        end
      end
      S_LAST: begin
        if (out_free) begin
          out_r.write_valid  <= hold_v_r;
          out_r.pixel_x      <= hold_v_r ? hold_x_r : '0;
          out_r.pixel_y      <= hold_v_r ? hold_y_r : '0;
          out_r.pixel_data   <= hold_v_r ? data_r : '0;
          out_r.last_of_line <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_pix.valid        = out_v_r;
  assign out_pix.write_valid  = out_r.write_valid;
  assign out_pix.pixel_x      = out_r.pixel_x;
  assign out_pix.pixel_y      = out_r.pixel_y;
  assign out_pix.pixel_data   = out_r.pixel_data;
  assign out_pix.last_of_line = out_r.last_of_line;

  // nothing held over from a finished line
  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_v_r)
    else $error("held point survives end of line");

  // stepping never runs past the end of the major axis
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (major_pos_r <= major_end_r))
    else $error("major position beyond end");

  // leaving the final phase always presents the line's last result
  a_last_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LAST && out_free) |=> (out_v_r && out_r.last_of_line))
    else $error("last result not presented");

  // an empty result only ever closes a line
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.write_valid) |-> out_r.last_of_line)
    else $error("non-write result without last mark");

endmodule

`default_nettype wire

// File: bench/line_rasterizer_with_clipping_unit_tb.sv
// Self-checking bench for line_rasterizer_with_clipping_unit: line requests in,
// pixel writes checked in order against a behavioral Bresenham tracer.
// Depends on lrc_pkg, lrc_if and the RTL of the unit.
`timescale 1ns / 1ps

module line_rasterizer_with_clipping_unit_tb;

  localparam int SCREEN_W       = lrc_pkg::SCREEN_W_DEF;
  localparam int SCREEN_H       = lrc_pkg::SCREEN_H_DEF;
  localparam int MAX_WRITES     = 64;     // at most one visible point per major step
  localparam int RANDOM_LINES   = 450;
  localparam int WATCHDOG_LIMIT = 20000;  // longest line is ~4100 steps with no write
  localparam int SETTLE_CYCLES  = 64;

  // receiver back-pressure styles
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_SQUARE} rx_mode_t;

  typedef struct {
    logic signed [lrc_pkg::COORD_W-1:0] sx;
    logic signed [lrc_pkg::COORD_W-1:0] sy;
    logic signed [lrc_pkg::COORD_W-1:0] ex;
    logic signed [lrc_pkg::COORD_W-1:0] ey;
    logic [lrc_pkg::DATA_W-1:0]         value;
  } line_req_t;

  logic clk;
  logic rst_n;

  lrc_req_if req_ch ();
  lrc_pix_if pix_ch ();

  line_rasterizer_with_clipping_unit #(
    .SCREEN_WIDTH  (SCREEN_W),
    .SCREEN_HEIGHT (SCREEN_H)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_pix (pix_ch)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  line_req_t     line_queue[$];        // requests not yet offered to the unit
  lrc_pkg::pix_t pixel_writes_due[$];  // predicted results, oldest first
  line_req_t     held_req;             // request currently on the input channel
  int            total_lines;
  int            directed_lines;
  int            lines_sent;
  int            pixels_seen;
  int            blank_lines_seen;
  int            mismatch_count;
  int            burst_left;
  int            gap_left;
  int            quiet_cycles;
  rx_mode_t      rx_mode;
  int            rx_mode_left;
  int            rx_tick;

  // ---------------------------------------------------------------------------
  // Bresenham tracer: walks the major axis one point at a time and queues a
  // write for every point that lands on screen. A line with no visible point
  // yields a single blank marker with the last flag set.
  // ---------------------------------------------------------------------------
  function automatic void trace_line(line_req_t r);
    int            a_maj, a_min, b_maj, b_min, swap_tmp;
    int            dx, dy, d_maj, d_min, mpos, npos, err, px, py, n_writes;
    bit            steep, down;
    lrc_pkg::pix_t w;
    dx = int'(r.ex) - int'(r.sx);
    dy = int'(r.ey) - int'(r.sy);
    steep = ((dy < 0) ? -dy : dy) > ((dx < 0) ? -dx : dx);
    if (steep) begin
      a_maj = r.sy; a_min = r.sx; b_maj = r.ey; b_min = r.ex;
    end else begin
      a_maj = r.sx; a_min = r.sy; b_maj = r.ex; b_min = r.ey;
    end
    // order so the major coordinate increases
    if (a_maj > b_maj) begin
      swap_tmp = a_maj; a_maj = b_maj; b_maj = swap_tmp;
      swap_tmp = a_min; a_min = b_min; b_min = swap_tmp;
    end
    down = !(a_min < b_min);
    d_maj = b_maj - a_maj;
    d_min = (b_min - a_min < 0) ? a_min - b_min : b_min - a_min;
    npos = a_min;
    err = 0;
    n_writes = 0;
    for (mpos = a_maj; mpos <= b_maj; mpos++) begin
      px = steep ? npos : mpos;
      py = steep ? mpos : npos;
      if (px >= 0 && py >= 0 && px < SCREEN_W && py < SCREEN_H && n_writes < MAX_WRITES) begin
        w.write_valid  = 1'b1;
        w.pixel_x      = px[lrc_pkg::PIX_W-1:0];
        w.pixel_y      = py[lrc_pkg::PIX_W-1:0];
        w.pixel_data   = r.value;
        w.last_of_line = 1'b0;
        pixel_writes_due.push_back(w);
        n_writes++;
      end
      if (2 * (err + d_min) < d_maj) begin
        err += d_min;
      end else begin
        npos += down ? -1 : 1;
        err += d_min - d_maj;
      end
    end
    if (n_writes == 0) begin
      w = '0;
      w.last_of_line = 1'b1;
    end else begin
      // only this call's writes sit at the back of the queue
      w = pixel_writes_due.pop_back();
      w.last_of_line = 1'b1;
    end
    pixel_writes_due.push_back(w);
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic check_pixel(lrc_pkg::pix_t got);
    lrc_pkg::pix_t want;
    if (pixel_writes_due.size() == 0) begin
      flag_mismatch("result with nothing pending, pixel_x", got.pixel_x, -1);
      return;
    end
    want = pixel_writes_due.pop_front();
    if (got.write_valid !== want.write_valid)
      flag_mismatch("write_valid", got.write_valid, want.write_valid);
    if (got.pixel_x !== want.pixel_x)
      flag_mismatch("pixel_x", got.pixel_x, want.pixel_x);
    if (got.pixel_y !== want.pixel_y)
      flag_mismatch("pixel_y", got.pixel_y, want.pixel_y);
    if (got.pixel_data !== want.pixel_data)
      flag_mismatch("pixel_data", got.pixel_data, want.pixel_data);
    if (got.last_of_line !== want.last_of_line)
      flag_mismatch("last_of_line", got.last_of_line, want.last_of_line);
  endtask

  function automatic logic signed [lrc_pkg::COORD_W-1:0] pick(int lo, int hi);
    pick = lrc_pkg::COORD_W'(lo + int'($urandom_range(hi - lo, 0)));
  endfunction

  function automatic void add_line(int sx, int sy, int ex, int ey, int value);
    line_req_t r;
    r.sx = lrc_pkg::COORD_W'(sx);
    r.sy = lrc_pkg::COORD_W'(sy);
    r.ex = lrc_pkg::COORD_W'(ex);
    r.ey = lrc_pkg::COORD_W'(ey);
    r.value = lrc_pkg::DATA_W'(value);
    line_queue.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: bursts of back-to-back requests separated by random gaps.
  // A request stays on the channel until accepted; its expected writes are
  // queued at the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        trace_line(held_req);
        lines_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0 || line_queue.size() == 0) begin
          req_ch.valid <= 1'b0;
          if (gap_left > 0)
            gap_left--;
        end else begin
          held_req = line_queue.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.start_x     <= held_req.sx;
          req_ch.start_y     <= held_req.sy;
          req_ch.end_x       <= held_req.ex;
          req_ch.end_y       <= held_req.ey;
          req_ch.pixel_value <= held_req.value;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 8);
            case ($urandom_range(0, 3))
              0, 2:    gap_left = 0;                      // keep streaming
              1:       gap_left = $urandom_range(1, 3);
              default: gap_left = $urandom_range(5, 20);
            endcase
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel monitor and receiver back-pressure. Each accepted result is checked
  // against the oldest prediction; ready follows a style that is picked anew at
  // random, including long stretches of no stall at all.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.ready <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        check_pixel('{pix_ch.write_valid, pix_ch.pixel_x, pix_ch.pixel_y,
                      pix_ch.pixel_data, pix_ch.last_of_line});
        if (pix_ch.write_valid)
          pixels_seen++;
        else
          blank_lines_seen++;
      end
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(50, 300);
      end else begin
        rx_mode_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   pix_ch.ready <= 1'b1;
        RX_COIN:   pix_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: pix_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   pix_ch.ready <= rx_tick[2];
      endcase
    end
  end

  // Watchdog: no request or result accepted for too long means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles, %0d writes still due",
                 $time, quiet_cycles, pixel_writes_due.size());
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and run control
  // ---------------------------------------------------------------------------
  initial begin
    int kind, ax, ay, bx, by, d;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.start_x = '0;
    req_ch.start_y = '0;
    req_ch.end_x = '0;
    req_ch.end_y = '0;
    req_ch.pixel_value = '0;
    pix_ch.ready = 1'b0;
    lines_sent = 0;
    pixels_seen = 0;
    blank_lines_seen = 0;
    mismatch_count = 0;
    burst_left = 4;
    gap_left = 0;
    quiet_cycles = 0;
    rx_mode = RX_OPEN;
    rx_mode_left = 0;
    rx_tick = 0;

    // directed lines
    add_line(0, 0, 63, 63, 8'hFF);              // full diagonal, 64 writes
    add_line(-2048, -2048, 2047, 2047, 8'h00);  // coordinate extremes through screen
    add_line(2047, -2048, -2048, 2047, 8'hA5);  // long diagonal that misses the screen
    add_line(2047, 2047, -2048, -2048, 8'h5A);  // coordinate extremes again, endpoints reversed
    add_line(5, 5, 5, 5, 8'h11);                // single point on screen
    add_line(64, 10, 64, 10, 8'h22);            // single point just off the right edge
    add_line(-1, -1, -1, -1, 8'h33);            // single point off the top-left corner
    add_line(0, 0, 63, 0, 8'h44);               // top row
    add_line(63, 63, 0, 63, 8'h55);             // bottom row, drawn right to left
    add_line(0, 63, 0, 0, 8'h66);               // left column, steep and reversed
    add_line(63, 0, 63, 63, 8'h77);             // right column
    add_line(0, 0, 63, 20, 8'h88);              // shallow, minor up
    add_line(63, 0, 0, 20, 8'h99);              // shallow, reordered, minor down
    add_line(10, 0, 30, 63, 8'hAA);             // steep, minor up
    add_line(30, 0, 10, 63, 8'hBB);             // steep, minor down
    add_line(-10, -5, 70, 40, 8'hCC);           // clipped at both ends
    add_line(100, 100, 200, 300, 8'hDD);        // wholly off screen
    add_line(-30, 10, 90, 12, 8'hEE);           // wider than the screen
    add_line(0, 0, 2047, 1, 8'h01);             // very long and nearly flat
    add_line(-2048, 0, 2047, 0, 8'h80);         // longest possible span
    add_line(32, -2048, 33, 2047, 8'h7F);       // longest steep span
    add_line(3, 7, 9, 4, 8'h0F);                // error lands exactly on the step threshold
    add_line(0, 0, 4, 2, 8'hF0);
    directed_lines = line_queue.size();

    // random lines; most touch the screen so the clipping edges are exercised
    for (int i = 0; i < RANDOM_LINES; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        // short lines around the screen
        add_line(pick(-20, 83), pick(-20, 83), pick(-20, 83), pick(-20, 83),
                 $urandom_range(0, 255));
      end else if (kind < 70) begin
        // one end on screen, the other well outside
        add_line(pick(0, 63), pick(0, 63), pick(-400, 460), pick(-400, 460),
                 $urandom_range(0, 255));
      end else if (kind < 78) begin
        // axis-aligned or degenerate
        ax = pick(-8, 71);
        ay = pick(-8, 71);
        case ($urandom_range(0, 2))
          0:       add_line(ax, ay, pick(-8, 71), ay, $urandom_range(0, 255));
          1:       add_line(ax, ay, ax, pick(-8, 71), $urandom_range(0, 255));
          default: add_line(ax, ay, ax, ay, $urandom_range(0, 255));
        endcase
      end else if (kind < 85) begin
        // exact 45 degree lines, either direction
        ax = pick(-10, 73);
        ay = pick(-10, 73);
        d = pick(1, 80);
        bx = ($urandom_range(0, 1) != 0) ? ax + d : ax - d;
        by = ($urandom_range(0, 1) != 0) ? ay + d : ay - d;
        add_line(ax, ay, bx, by, $urandom_range(0, 255));
      end else if (kind < 93) begin
        // anywhere in the coordinate range, usually invisible
        add_line(pick(-2048, 2047), pick(-2048, 2047), pick(-2048, 2047),
                 pick(-2048, 2047), $urandom_range(0, 255));
      end else begin
        // long line from the screen to anywhere
        add_line(pick(-2048, 2047), pick(-2048, 2047), pick(0, 63), pick(0, 63),
                 $urandom_range(0, 255));
      end
    end
    total_lines = line_queue.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // every request accepted, then every predicted result received
    while (lines_sent < total_lines)
      @(posedge clk);
    while (pixel_writes_due.size() != 0)
      @(posedge clk);
    // catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d line requests (%0d directed, %0d random) under bursty input",
             lines_sent, directed_lines, total_lines - directed_lines);
    $display("and stalled output: %0d pixel writes and %0d blank lines checked",
             pixels_seen, blank_lines_seen);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/lrc_pkg.sv
rtl/lrc_if.sv
rtl/lrc_front.sv
rtl/lrc_queue.sv
rtl/lrc_back.sv
rtl/line_rasterizer_with_clipping_unit.sv
bench/line_rasterizer_with_clipping_unit_tb.sv
